[hdl/indexed_deque_macros.svh]
// Assertion helpers for the indexed deque.
`ifndef INDEXED_DEQUE_MACROS_SVH
`define INDEXED_DEQUE_MACROS_SVH

// Clocked check, masked while reset is held.
`define IDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked check that also holds through reset.
`define IDQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

[hdl/idq_pkg.sv]
package idq_pkg;

    // store geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // field widths
    localparam int REQ_W = 3;
    localparam int VAL_W = 32;
    localparam int POS_W = 4;
    localparam int ST_W  = 2;
    localparam int RD_W  = 32;
    localparam int EC_W  = 5;

    localparam int IN_TDATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RD_W + EC_W + 7) / 8) * 8;

    typedef logic [REQ_W-1:0]      t_req;
    typedef logic [ST_W-1:0]       t_status;
    typedef logic [PTR_W-1:0]      t_ptr;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [DATA_WIDTH-1:0] t_data;

    localparam t_req REQ_PUSH_FRONT = 3'd0;
    localparam t_req REQ_PUSH_BACK  = 3'd1;
    localparam t_req REQ_POP_FRONT  = 3'd2;
    localparam t_req REQ_POP_BACK   = 3'd3;
    localparam t_req REQ_READ_AT    = 3'd4;
    localparam t_req REQ_WRITE_AT   = 3'd5;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
    localparam t_status ST_RANGE = 2'd3;

    // ring add, both operands below DEPTH
    function automatic t_ptr wrap_add(input t_ptr a, input t_ptr b);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PTR_W+1)'(DEPTH)) begin
            s = s - (PTR_W+1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

[hdl/indexed_deque.sv]
// indexed_deque: bounded double-ended queue on a 16-entry register ring.
// Each request passes the input register, then the result register; a stall on the
//   result channel holds both.
// Throughput: one request per cycle while the result channel is not stalled; each request
//   reads or writes one ring slot and updates the front pointer and count in a single pass.
// Reset (i_rst_n low, synchronous): front pointer, count and both valid flags clear;
//   ring contents are not cleared and are only read once written.
`include "indexed_deque_macros.svh"

module indexed_deque (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: [31:0] item_value, [35:32] position, [39:36] zero
    input  logic [idq_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: [2:0] req_type
    input  logic [idq_pkg::REQ_W-1:0]        i_s_axis_tuser,
    // result channel
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata: [31:0] read_data, [36:32] entry_count, [39:37] zero
    output logic [idq_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // tuser: [1:0] status
    output logic [idq_pkg::ST_W-1:0]         o_m_axis_tuser
);
    import idq_pkg::*;

    // ------------------------------------------------------------------
    // Input register stage
    // ------------------------------------------------------------------
    logic              r_in_valid;
    t_req              r_req;
    logic [VAL_W-1:0]  r_val;
    logic [POS_W-1:0]  r_pos;

    // ------------------------------------------------------------------
    // Deque state
    // ------------------------------------------------------------------
    t_data             r_store [DEPTH];
    t_ptr              r_front;
    t_cnt              r_count;

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic              r_out_valid;
    t_status           r_out_status;
    logic [RD_W-1:0]   r_out_rd;
    logic [EC_W-1:0]   r_out_count;

    logic              in_xfer;
    logic              advance;

    // Input stage moves on when the result register is empty or drains this cycle.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    // ------------------------------------------------------------------
    // Request decode and state update
    // ------------------------------------------------------------------
    t_status           n_status;
    logic [RD_W-1:0]   n_rd;
    t_cnt              n_count;
    t_ptr              n_front;
    logic              wr_en;
    t_ptr              wr_addr;
    t_ptr              rd_addr;
    t_data             rd_raw;
    t_data             wr_data;
    t_ptr              front_dec;
    t_ptr              front_inc;
    t_ptr              back_slot;   // slot one past the last entry
    t_ptr              last_slot;   // slot of the last entry
    t_ptr              pos_slot;
    t_cnt              count_m1;
    logic              is_full;
    logic              is_empty;
    logic              pos_ok;

    assign is_full   = (r_count == CNT_W'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign pos_ok    = (CNT_W'(r_pos) < r_count);
    assign count_m1  = r_count - CNT_W'(1);
    assign front_dec = (r_front == '0) ? PTR_W'(DEPTH - 1) : r_front - PTR_W'(1);
    assign front_inc = wrap_add(r_front, PTR_W'(1));
    assign back_slot = wrap_add(r_front, r_count[PTR_W-1:0]);
    assign last_slot = wrap_add(r_front, count_m1[PTR_W-1:0]);
    assign pos_slot  = wrap_add(r_front, PTR_W'(r_pos));
    assign wr_data   = DATA_WIDTH'(signed'(r_val));
    assign rd_raw    = r_store[rd_addr];

    always_comb begin
        n_status = ST_OK;
        n_rd     = '0;
        n_count  = r_count;
        n_front  = r_front;
        wr_en    = 1'b0;
        wr_addr  = front_dec;
        rd_addr  = r_front;
        unique case (r_req)
            REQ_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = front_dec;
                    n_front = front_dec;
                    n_count = r_count + CNT_W'(1);
                end
            end
            REQ_PUSH_BACK: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = back_slot;
                    n_count = r_count + CNT_W'(1);
                end
            end
            REQ_POP_FRONT: begin
                rd_addr = r_front;
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_rd    = RD_W'(signed'(rd_raw));
                    n_front = front_inc;
                    n_count = count_m1;
                end
            end
            REQ_POP_BACK: begin
                rd_addr = last_slot;
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_rd    = RD_W'(signed'(rd_raw));
                    n_count = count_m1;
                end
            end
            REQ_READ_AT: begin
                rd_addr = pos_slot;
                if (!pos_ok) begin
                    n_status = ST_RANGE;
                end else begin
                    n_rd = RD_W'(signed'(rd_raw));
                end
            end
            REQ_WRITE_AT: begin
                wr_addr = pos_slot;
                if (!pos_ok) begin
                    n_status = ST_RANGE;
                end else begin
                    wr_en = 1'b1;
                end
            end
            default: begin
                // unused codes: report ok and leave everything as is
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_front     <= '0;
            r_count     <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_front     <= n_front;
                r_count     <= n_count;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers and ring store
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req <= i_s_axis_tuser;
            r_val <= i_s_axis_tdata[VAL_W-1:0];
            r_pos <= i_s_axis_tdata[VAL_W +: POS_W];
        end
        if (advance) begin
            r_out_status <= n_status;
            r_out_rd     <= n_rd;
            r_out_count  <= EC_W'(n_count);
        end
        if (advance && wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - RD_W - EC_W)'(0), r_out_count, r_out_rd};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic              req_err;     // request rejected in this pass
    logic              push_ok;     // push taken in this pass
    logic              out_err;     // result register holds an error

    assign req_err = advance && (n_status != ST_OK);
    assign push_ok = advance && (n_status == ST_OK)
                     && ((r_req == REQ_PUSH_FRONT) || (r_req == REQ_PUSH_BACK));
    assign out_err = r_out_valid && (r_out_status != ST_OK);

    `IDQ_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !r_in_valid && !r_out_valid, "stale valid")
    `IDQ_ASSERT(a_count_bound, r_count <= CNT_W'(DEPTH), "entry count above depth")
    `IDQ_ASSERT(a_err_no_change, req_err |=> $stable(r_count) && $stable(r_front), "state moved")
    `IDQ_ASSERT(a_push_grows, push_ok |=> r_count == $past(r_count) + CNT_W'(1), "push lost")
    `IDQ_ASSERT(a_err_zero_data, out_err |-> r_out_rd == '0, "error result carries data")

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

// Bench for the indexed deque: requests go in on the slave stream, one response per
// request comes back on the master stream. A mirror of the ring (slots, front
// pointer, entry count) is advanced for every request the moment it is accepted,
// and the response it predicts is queued; the monitor compares every response
// transfer field by field against the oldest queued prediction.
module tb;
    import idq_pkg::*;

    // codes the block ignores
    localparam t_req REQ_SPARE_6 = 3'd6;
    localparam t_req REQ_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1750;
    localparam int HOLD_CYCLES  = 120;   // long receiver hold-off, fills the pipeline
    localparam int HOLD_EVERY   = 600;   // accepted requests between hold-offs
    localparam int DRAIN_CYCLES = 16;    // short drain after the last response, leave some slack

    typedef struct {
        t_req             req;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
    } t_deque_req;

    typedef struct {
        t_status          status;
        logic [RD_W-1:0]  rd;
        logic [EC_W-1:0]  cnt;
    } t_deque_resp;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;    // [31:0] item_value, [35:32] position
    logic [REQ_W-1:0]       s_tuser = '0;    // [2:0] req_type
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // [31:0] read_data, [36:32] entry_count
    logic [ST_W-1:0]        m_tuser;         // [1:0] status

    indexed_deque dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Mirror of the ring. Slots are only read at positions below the count,
    // so they always hold something a push or a write put there.
    // ------------------------------------------------------------------
    t_data ring_mirror [DEPTH];
    t_ptr  front_mirror = '0;
    int    held_mirror = 0;

    function automatic t_ptr slot_at(int p);
        return t_ptr'((int'(front_mirror) + p) % DEPTH);
    endfunction

    // stored word, sign-extended to the response width
    function automatic logic [RD_W-1:0] widen(t_data v);
        return RD_W'(signed'(v));
    endfunction

    function automatic t_deque_resp mirror_request(t_deque_req r);
        t_deque_resp e;
        t_data       v;
        e.status = ST_OK;
        e.rd     = '0;
        v        = t_data'(signed'(r.value));
        case (r.req)
            REQ_PUSH_FRONT: begin
                if (held_mirror >= DEPTH) begin
                    e.status = ST_FULL;
                end else begin
                    front_mirror = slot_at(DEPTH - 1);
                    ring_mirror[front_mirror] = v;
                    held_mirror++;
                end
            end
            REQ_PUSH_BACK: begin
                if (held_mirror >= DEPTH) begin
                    e.status = ST_FULL;
                end else begin
                    ring_mirror[slot_at(held_mirror)] = v;
                    held_mirror++;
                end
            end
            REQ_POP_FRONT: begin
                if (held_mirror == 0) begin
                    e.status = ST_EMPTY;
                end else begin
                    e.rd = widen(ring_mirror[front_mirror]);
                    front_mirror = slot_at(1);
                    held_mirror--;
                end
            end
            REQ_POP_BACK: begin
                if (held_mirror == 0) begin
                    e.status = ST_EMPTY;
                end else begin
                    e.rd = widen(ring_mirror[slot_at(held_mirror - 1)]);
                    held_mirror--;
                end
            end
            REQ_READ_AT: begin
                if (int'(r.pos) >= held_mirror) begin
                    e.status = ST_RANGE;
                end else begin
                    e.rd = widen(ring_mirror[slot_at(int'(r.pos))]);
                end
            end
            REQ_WRITE_AT: begin
                if (int'(r.pos) >= held_mirror) begin
                    e.status = ST_RANGE;
                end else begin
                    ring_mirror[slot_at(int'(r.pos))] = v;
                end
            end
            default: begin
                // spare codes: no effect, count reported as is
            end
        endcase
        e.cnt = EC_W'(held_mirror);
        return e;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus. The generator tracks the entry count on its own so that it
    // can build fill, drain and in-range indexed sequences ahead of time.
    // ------------------------------------------------------------------
    t_deque_req  request_backlog [$];
    t_deque_resp awaited_responses [$];
    int          gen_held = 0;
    int          random_sent = 0;

    task automatic queue_request(t_req req, logic [VAL_W-1:0] value, logic [POS_W-1:0] pos);
        t_deque_req r;
        r.req   = req;
        r.value = value;
        r.pos   = pos;
        request_backlog.insert(request_backlog.size(), r);
        if (req == REQ_PUSH_FRONT || req == REQ_PUSH_BACK) begin
            if (gen_held < DEPTH) gen_held++;
        end else if (req == REQ_POP_FRONT || req == REQ_POP_BACK) begin
            if (gen_held > 0) gen_held--;
        end
        if (req <= REQ_WRITE_AT) random_sent++;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // mostly a live position, sometimes anything
    function automatic logic [POS_W-1:0] pick_pos();
        if (gen_held > 0 && $urandom_range(0, 99) < 85) begin
            return POS_W'($urandom_range(0, gen_held - 1));
        end
        return POS_W'($urandom_range(0, DEPTH - 1));
    endfunction

    function automatic t_req pick_push();
        return $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
    endfunction

    function automatic t_req pick_pop();
        return $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
    endfunction

    initial begin
        int pick;
        int goal;
        int n;
        // empty-store errors, spare codes
        queue_request(REQ_POP_FRONT, 32'h1111_1111, 4'd0);
        queue_request(REQ_POP_BACK, 32'h2222_2222, 4'd0);
        queue_request(REQ_READ_AT, 32'h0, 4'd0);
        queue_request(REQ_WRITE_AT, 32'hdead_beef, 4'd15);
        queue_request(REQ_SPARE_6, 32'hffff_ffff, 4'd15);
        queue_request(REQ_SPARE_7, 32'h8000_0000, 4'd7);
        // push at both ends; front push from slot 0 wraps the pointer
        queue_request(REQ_PUSH_FRONT, 32'h8000_0000, 4'd0);
        queue_request(REQ_PUSH_BACK, 32'h7fff_ffff, 4'd0);
        queue_request(REQ_PUSH_FRONT, 32'hffff_ffff, 4'd0);
        queue_request(REQ_PUSH_BACK, 32'h0000_0000, 4'd0);
        queue_request(REQ_READ_AT, 32'h0, 4'd0);
        queue_request(REQ_READ_AT, 32'h0, 4'd3);
        queue_request(REQ_READ_AT, 32'h0, 4'd4);     // one past the end
        queue_request(REQ_WRITE_AT, 32'h1234_5678, 4'd3);
        queue_request(REQ_WRITE_AT, 32'h5a5a_5a5a, 4'd8);
        queue_request(REQ_READ_AT, 32'h0, 4'd3);
        queue_request(REQ_POP_BACK, 32'h0, 4'd0);
        queue_request(REQ_POP_FRONT, 32'h0, 4'd0);
        queue_request(REQ_POP_FRONT, 32'h0, 4'd0);
        queue_request(REQ_POP_BACK, 32'h0, 4'd0);
        queue_request(REQ_POP_BACK, 32'h0, 4'd0);    // empty again

        random_sent = 0;
        // first random sequence: fill to full, overflow, read the last slot
        while (gen_held < DEPTH) queue_request(pick_push(), pick_value(), 4'd0);
        queue_request(pick_push(), pick_value(), 4'd0);
        queue_request(REQ_READ_AT, pick_value(), 4'd15);
        queue_request(REQ_WRITE_AT, pick_value(), 4'd15);

        while (random_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                // fill, to full half the time, with a push or two past it
                goal = (pick < 10) ? DEPTH : $urandom_range(gen_held, DEPTH);
                while (gen_held < goal) queue_request(pick_push(), pick_value(), pick_pos());
                if (goal == DEPTH) begin
                    n = $urandom_range(0, 2);
                    repeat (n) queue_request(pick_push(), pick_value(), pick_pos());
                end
            end else if (pick < 35) begin
                // drain, to empty half the time, with a pop or two past it
                goal = (pick < 27) ? 0 : $urandom_range(0, gen_held);
                while (gen_held > goal) queue_request(pick_pop(), pick_value(), pick_pos());
                if (goal == 0) begin
                    n = $urandom_range(0, 2);
                    repeat (n) queue_request(pick_pop(), pick_value(), pick_pos());
                end
            end else if (pick < 92) begin
                // mixed traffic, indexed accesses mostly in range
                n = $urandom_range(8, 30);
                repeat (n) begin
                    case ($urandom_range(0, 5))
                        0, 1: queue_request(pick_push(), pick_value(), pick_pos());
                        2:    queue_request(pick_pop(), pick_value(), pick_pos());
                        3, 4: queue_request(REQ_READ_AT, pick_value(), pick_pos());
                        default: queue_request(REQ_WRITE_AT, pick_value(), pick_pos());
                    endcase
                end
            end else begin
                // noise: any code, any position
                n = $urandom_range(1, 4);
                repeat (n) begin
                    queue_request(t_req'($urandom_range(0, 7)), pick_value(),
                                  POS_W'($urandom_range(0, DEPTH - 1)));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Idle gaps: mostly none or short, a few long, and now and then a
    // calm stretch with no gaps at all.
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    int hold_left = 0;
    int holds_done = 0;
    int req_accepted = 0;
    bit req_taken = 1'b0;

    // Long receiver hold-off, counted here. The sender keeps offering, so
    // the block fills and must drop s_tready.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && req_accepted >= (holds_done + 1) * HOLD_EVERY) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Request driver: a new transfer is presented once the previous one was
    // taken at the last rising edge, after its gap has run out.
    int         send_gap = 0;
    int         send_calm = 0;
    t_deque_req next_req;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap--;
            end else if (request_backlog.size() > 0) begin
                next_req = request_backlog[0];
                request_backlog.delete(0);
                s_tvalid <= 1'b1;
                s_tdata  <= {{(IN_TDATA_W - VAL_W - POS_W){1'b0}}, next_req.pos, next_req.value};
                s_tuser  <= next_req.req;
                if (hold_left > 0) begin
                    send_gap = 0;            // keep pushing into the stalled block
                end else if (send_calm > 0) begin
                    send_calm--;
                    send_gap = 0;
                end else begin
                    if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 80);
                    send_gap = pick_gap();
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Response ready with random stalls
    int recv_gap = 0;
    int recv_calm = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            m_tready <= 1'b0;
            recv_gap--;
        end else begin
            m_tready <= 1'b1;
            if (recv_calm > 0) begin
                recv_calm--;
            end else begin
                if ($urandom_range(0, 49) == 0) recv_calm = $urandom_range(20, 80);
                recv_gap = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Sampling at the rising edge: accepted requests feed the mirror,
    // response transfers are checked against the oldest prediction.
    // ------------------------------------------------------------------
    int mismatches = 0;

    always @(posedge i_clk) begin : sample
        t_deque_req  taken;
        t_deque_resp want;
        t_deque_resp got;
        req_taken = 1'b0;
        if (i_rst_n && s_tvalid && s_tready) begin
            taken.value = s_tdata[VAL_W-1:0];
            taken.pos   = s_tdata[VAL_W +: POS_W];
            taken.req   = s_tuser;
            awaited_responses.insert(awaited_responses.size(), mirror_request(taken));
            req_taken = 1'b1;
            req_accepted++;
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.rd     = m_tdata[RD_W-1:0];
            got.cnt    = m_tdata[RD_W +: EC_W];
            if (awaited_responses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: response with none pending: status %0d data %h count %0d",
                             $realtime, got.status, got.rd, got.cnt);
                end
            end else begin
                want = awaited_responses[0];
                awaited_responses.delete(0);
                if (want.status !== got.status || want.rd !== got.rd || want.cnt !== got.cnt) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: mismatch: expected status %0d data %h count %0d",
                                 $realtime, want.status, want.rd, want.cnt);
                        $display("%0t:           got      status %0d data %h count %0d",
                                 $realtime, got.status, got.rd, got.cnt);
                    end
                end
            end
        end
    end

    // End of run: everything sent, every response in, then a short drain
    // to catch stray transfers.
    initial begin
        do begin
            @(negedge i_clk);
        end while (!(i_rst_n && request_backlog.size() == 0 && !s_tvalid
                     && awaited_responses.size() == 0));
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && awaited_responses.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: a correct run with the worst gaps and stalls ends far sooner.
    initial begin
        #(8_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
